@@ hw/rtl/pmld_pkg.sv @@
// Shared types and codes for the pooled multi-list directory.
package pmld_pkg;

  localparam int KEY_W = 200;
  localparam int CITY_W = 120;
  localparam int AGE_W = 8;
  localparam int LIST_CAP = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_MOVE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_NONE   = 3'd0,
    RES_FULL   = 3'd1,
    RES_MISS   = 3'd2,
    RES_FOUND  = 3'd3,
    RES_APPEND = 3'd4
  } res_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic take_slot;
    logic rd_head;
    logic app_w1;
    logic app_w2;
    logic walk_adv;
    logic unlink;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic list_ok;
    logic is_insert;
    logic is_lookup;
    logic is_move;
    logic nonempty;
    logic slot_free;
    logic scan_last;
    logic key_match;
    logic walk_end;
  } sts_t;

endpackage

@@ hw/rtl/pmld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pmld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pmld_ctrl.sv @@
// Operation sequencer for the pooled multi-list directory.
module pmld_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pmld_pkg::sts_t sts,
  output pmld_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_APP_RD   = 9'b000001000,
    S_APP_W1   = 9'b000010000,
    S_APP_W2   = 9'b000100000,
    S_WALK_RD  = 9'b001000000,
    S_WALK_CMP = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res = pmld_pkg::RES_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.list_ok) begin
          cmd.res = pmld_pkg::RES_MISS;
          state_next = S_DONE;
        end else if (sts.is_insert) begin
          state_next = S_SCAN;
        end else if (!sts.nonempty) begin
          cmd.res = pmld_pkg::RES_MISS;
          state_next = S_DONE;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_SCAN: begin
        if (sts.slot_free) begin
          cmd.take_slot = 1'b1;
          state_next = sts.nonempty ? S_APP_RD : S_APP_W1;
        end else if (sts.scan_last) begin
          cmd.res = pmld_pkg::RES_FULL;
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APP_RD: begin
        // fetch the tail link of the head
        cmd.rd_head = 1'b1;
        state_next = S_APP_W1;
      end
      S_APP_W1: begin
        cmd.app_w1 = 1'b1;
        if (sts.nonempty) begin
          state_next = S_APP_W2;
        end else begin
          cmd.res = pmld_pkg::RES_APPEND;
          state_next = S_DONE;
        end
      end
      S_APP_W2: begin
        cmd.app_w2 = 1'b1;
        cmd.res = pmld_pkg::RES_APPEND;
        state_next = S_DONE;
      end
      S_WALK_RD: begin
        state_next = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (sts.key_match) begin
          if (sts.is_lookup) begin
            cmd.res = pmld_pkg::RES_FOUND;
            state_next = S_DONE;
          end else if (sts.is_move) begin
            cmd.unlink = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.unlink = 1'b1;
            cmd.res = pmld_pkg::RES_FOUND;
            state_next = S_DONE;
          end
        end else if (sts.walk_end) begin
          cmd.res = pmld_pkg::RES_MISS;
          state_next = S_DONE;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next = S_WALK_RD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/pmld_dpath.sv @@
// Record stores, link RAMs, slot map and result registers.
module pmld_dpath #(
  parameter int SLOTS = 32,
  parameter int LISTS = 3,
  localparam int SLOT_W = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pmld_pkg::cmd_t        cmd,
  output pmld_pkg::sts_t        sts,
  input  logic [1:0]            kind,
  input  logic [1:0]            list_sel,
  input  logic [1:0]            dest_list,
  input  logic [63:0]           nick_0,
  input  logic [63:0]           nick_1,
  input  logic [63:0]           nick_2,
  input  logic [7:0]            nick_3,
  input  logic [63:0]           city_0,
  input  logic [55:0]           city_1,
  input  logic [7:0]            age_in,
  output logic [1:0]            status,
  output logic [SLOT_W-1:0]     slot_index,
  output logic [63:0]           city_out_0,
  output logic [55:0]           city_out_1,
  output logic [7:0]            age_out
);

  localparam int CA_W = pmld_pkg::CITY_W + pmld_pkg::AGE_W;

  logic [1:0]                    kind_q;
  logic [1:0]                    lst_q;
  logic [1:0]                    dst_q;
  logic                          ok_q;
  logic [pmld_pkg::KEY_W-1:0]    key_q;
  logic [pmld_pkg::CITY_W-1:0]   city_q;
  logic [pmld_pkg::AGE_W-1:0]    age_q;
  logic [SLOT_W-1:0]             idx_q;
  logic [SLOT_W-1:0]             slot_q;
  logic [SLOT_W-1:0]             cur_q;
  logic [SLOT_W-1:0]             cnt_q;
  logic [SLOT_W-1:0]             tail_q;
  logic [SLOTS-1:0]              used_q;
  logic [SLOT_W-1:0]             head_q [pmld_pkg::LIST_CAP];
  logic [pmld_pkg::LIST_CAP-1:0] nonempty_q;

  logic [pmld_pkg::KEY_W-1:0]    key_term;
  logic [pmld_pkg::CITY_W-1:0]   city_term;
  logic [pmld_pkg::KEY_W-1:0]    key_rd;
  logic [CA_W-1:0]               ca_rd;
  logic [SLOT_W-1:0]             next_rd;
  logic [SLOT_W-1:0]             prev_rd;
  logic [SLOT_W-1:0]             hd;
  logic                          single;

  logic                          next_we;
  logic [SLOT_W-1:0]             next_wa;
  logic [SLOT_W-1:0]             next_wd;
  logic                          prev_we;
  logic [SLOT_W-1:0]             prev_wa;
  logic [SLOT_W-1:0]             prev_wd;
  logic [SLOT_W-1:0]             prev_ra;

  // zero every character after the first zero character
  always_comb begin
    logic ended;
    logic [pmld_pkg::KEY_W-1:0] kraw;
    logic [pmld_pkg::CITY_W-1:0] craw;
    kraw = {nick_3, nick_2, nick_1, nick_0};
    craw = {city_1, city_0};
    key_term = kraw;
    ended = 1'b0;
    for (int b = 0; b < pmld_pkg::KEY_W / 8; b++) begin
      if (ended) begin
        key_term[b*8 +: 8] = 8'd0;
      end else if (kraw[b*8 +: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    city_term = craw;
    ended = 1'b0;
    for (int b = 0; b < pmld_pkg::CITY_W / 8; b++) begin
      if (ended) begin
        city_term[b*8 +: 8] = 8'd0;
      end else if (craw[b*8 +: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
  end

  assign hd = head_q[lst_q];
  assign single = (next_rd == cur_q);

  assign sts.list_ok = ok_q;
  assign sts.is_insert = (kind_q == pmld_pkg::KIND_INSERT);
  assign sts.is_lookup = (kind_q == pmld_pkg::KIND_LOOKUP);
  assign sts.is_move = (kind_q == pmld_pkg::KIND_MOVE);
  assign sts.nonempty = nonempty_q[lst_q];
  assign sts.slot_free = !used_q[idx_q];
  assign sts.scan_last = (idx_q == SLOT_W'(SLOTS - 1));
  assign sts.key_match = (key_rd == key_q);
  assign sts.walk_end = (next_rd == hd) || (cnt_q == SLOT_W'(SLOTS - 1));

  // link RAM write ports
  always_comb begin
    next_we = 1'b0;
    next_wa = slot_q;
    next_wd = slot_q;
    prev_we = 1'b0;
    prev_wa = slot_q;
    prev_wd = slot_q;
    if (cmd.app_w1) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wd = nonempty_q[lst_q] ? hd : slot_q;
      prev_wd = nonempty_q[lst_q] ? prev_rd : slot_q;
    end else if (cmd.app_w2) begin
      next_we = 1'b1;
      next_wa = tail_q;
      prev_we = 1'b1;
      prev_wa = hd;
    end else if (cmd.unlink && !single) begin
      next_we = 1'b1;
      next_wa = prev_rd;
      next_wd = next_rd;
      prev_we = 1'b1;
      prev_wa = next_rd;
      prev_wd = prev_rd;
    end
  end

  assign prev_ra = cmd.rd_head ? hd : cur_q;

  pmld_ram #(.WIDTH(pmld_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.app_w1),
    .waddr (slot_q),
    .wdata (key_q),
    .raddr (cur_q),
    .rdata (key_rd)
  );

  pmld_ram #(.WIDTH(CA_W), .DEPTH(SLOTS)) u_ca_ram (
    .clk   (clk),
    .we    (cmd.app_w1),
    .waddr (slot_q),
    .wdata ({age_q, city_q}),
    .raddr (cur_q),
    .rdata (ca_rd)
  );

  pmld_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_wa),
    .wdata (next_wd),
    .raddr (cur_q),
    .rdata (next_rd)
  );

  pmld_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .raddr (prev_ra),
    .rdata (prev_rd)
  );

  // control state: slot map and list occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      used_q <= '0;
      nonempty_q <= '0;
    end else begin
      if (cmd.take_slot) begin
        used_q[idx_q] <= 1'b1;
      end
      if (cmd.unlink) begin
        used_q[cur_q] <= 1'b0;
        if (single) begin
          nonempty_q[lst_q] <= 1'b0;
        end
      end
      if (cmd.app_w1 && !nonempty_q[lst_q]) begin
        nonempty_q[lst_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      lst_q <= list_sel;
      dst_q <= dest_list;
      ok_q <= (32'(list_sel) < LISTS) &&
              ((kind != pmld_pkg::KIND_MOVE) || (32'(dest_list) < LISTS));
      key_q <= key_term;
      city_q <= city_term;
      age_q <= age_in;
      idx_q <= '0;
      cnt_q <= '0;
      cur_q <= head_q[list_sel];
    end
    if (cmd.scan_step) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd.take_slot) begin
      slot_q <= idx_q;
    end
    if (cmd.walk_adv) begin
      cur_q <= next_rd;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd.app_w1) begin
      tail_q <= prev_rd;
      if (!nonempty_q[lst_q]) begin
        head_q[lst_q] <= slot_q;
      end
    end
    if (cmd.unlink) begin
      if (!single && hd == cur_q) begin
        head_q[lst_q] <= next_rd;
      end
      // carry the record over for a move
      lst_q <= dst_q;
      city_q <= ca_rd[pmld_pkg::CITY_W-1:0];
      age_q <= ca_rd[CA_W-1 -: pmld_pkg::AGE_W];
      idx_q <= '0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    case (cmd.res) inside
      pmld_pkg::RES_FULL, pmld_pkg::RES_MISS: begin
        status <= (cmd.res == pmld_pkg::RES_FULL) ? pmld_pkg::ST_FULL : pmld_pkg::ST_MISS;
        slot_index <= '0;
        city_out_0 <= '0;
        city_out_1 <= '0;
        age_out <= '0;
      end
      pmld_pkg::RES_FOUND: begin
        status <= pmld_pkg::ST_DONE;
        slot_index <= cur_q;
        if (kind_q == pmld_pkg::KIND_LOOKUP) begin
          city_out_0 <= ca_rd[63:0];
          city_out_1 <= ca_rd[pmld_pkg::CITY_W-1:64];
          age_out <= ca_rd[CA_W-1 -: pmld_pkg::AGE_W];
        end else begin
          city_out_0 <= '0;
          city_out_1 <= '0;
          age_out <= '0;
        end
      end
      pmld_pkg::RES_APPEND: begin
        status <= pmld_pkg::ST_DONE;
        slot_index <= slot_q;
        city_out_0 <= '0;
        city_out_1 <= '0;
        age_out <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/pooled_multi_list_directory.sv @@
// Top level of the pooled multi-list directory.
// Insert: dispatch, a free-slot scan, then an append (head read and two link writes, or
// one write into an empty list); lookup and remove read and compare each record walked;
// move adds a scan and an append. One word at a time: busy stays high from start until the
// cycle after done. done pulses for one cycle with the result; the receiver cannot stall.
// Synchronous reset clears the slot map, list occupancy and sequencer.
module pooled_multi_list_directory #(
  parameter int SLOTS = 32,
  parameter int LISTS = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic [1:0]               kind,
  input  logic [1:0]               list_sel,
  input  logic [1:0]               dest_list,
  input  logic [63:0]              nick_0,
  input  logic [63:0]              nick_1,
  input  logic [63:0]              nick_2,
  input  logic [7:0]               nick_3,
  input  logic [63:0]              city_0,
  input  logic [55:0]              city_1,
  input  logic [7:0]               age_in,
  output logic [1:0]               status,
  output logic [$clog2(SLOTS)-1:0] slot_index,
  output logic [63:0]              city_out_0,
  output logic [55:0]              city_out_1,
  output logic [7:0]               age_out
);

  pmld_pkg::cmd_t cmd;
  pmld_pkg::sts_t sts;

  pmld_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pmld_dpath #(.SLOTS(SLOTS), .LISTS(LISTS)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .list_sel   (list_sel),
    .dest_list  (dest_list),
    .nick_0     (nick_0),
    .nick_1     (nick_1),
    .nick_2     (nick_2),
    .nick_3     (nick_3),
    .city_0     (city_0),
    .city_1     (city_1),
    .age_in     (age_in),
    .status     (status),
    .slot_index (slot_index),
    .city_out_0 (city_out_0),
    .city_out_1 (city_out_1),
    .age_out    (age_out)
  );

endmodule

@@ sim/pooled_multi_list_directory_tb.sv @@
// Self-checking testbench for the pooled multi-list directory.
module pooled_multi_list_directory_tb;

  localparam int SLOTS = 32;
  localparam int LISTS = 3;

  typedef struct {
    pmld_pkg::status_t st;
    logic [4:0]  slot;
    logic [63:0] c0;
    logic [55:0] c1;
    logic [7:0]  age;
  } answer_t;

  class directory_board;
    bit          used [SLOTS];
    logic [4:0]  prv [SLOTS];
    logic [4:0]  nxt [SLOTS];
    logic [199:0] keys [SLOTS];
    logic [119:0] cities [SLOTS];
    logic [7:0]  ages [SLOTS];
    logic [4:0]  head [LISTS];
    bit          filled [LISTS];
    answer_t     pending[$];
    int          errors;

    function void clear();
      foreach (used[i]) used[i] = 0;
      foreach (filled[i]) filled[i] = 0;
      pending.delete();
      errors = 0;
    endfunction

    // Zero every byte after the first zero byte.
    function logic [199:0] trim(logic [199:0] t, int nbytes);
      bit ended;
      ended = 0;
      for (int b = 0; b < nbytes; b++) begin
        if (ended) t[b*8 +: 8] = 8'h00;
        else if (t[b*8 +: 8] == 8'h00) ended = 1;
      end
      return t;
    endfunction

    function int find(int l, logic [199:0] k);
      int s;
      if (!filled[l]) return -1;
      s = head[l];
      for (int n = 0; n < SLOTS; n++) begin
        if (keys[s] == k) return s;
        s = nxt[s];
        if (s == head[l]) break;
      end
      return -1;
    endfunction

    function void unlink(int l, int s);
      if (nxt[s] == s) filled[l] = 0;
      else begin
        nxt[prv[s]] = nxt[s];
        prv[nxt[s]] = prv[s];
        if (head[l] == s) head[l] = nxt[s];
      end
      used[s] = 0;
    endfunction

    function int append(int l, logic [199:0] k, logic [119:0] c, logic [7:0] a);
      int s;
      logic [4:0] t;
      s = 0;
      while (s < SLOTS && used[s]) s++;
      if (s >= SLOTS) return -1;
      used[s] = 1; keys[s] = k; cities[s] = c; ages[s] = a;
      if (filled[l]) begin
        t = prv[head[l]];
        prv[s] = t; nxt[s] = head[l]; nxt[t] = 5'(s); prv[head[l]] = 5'(s);
      end else begin
        head[l] = 5'(s); prv[s] = 5'(s); nxt[s] = 5'(s); filled[l] = 1;
      end
      return s;
    endfunction

    function void note_word(pmld_pkg::kind_t k, int src, int dst, logic [199:0] key_raw,
                            logic [119:0] city_raw, logic [7:0] a);
      answer_t r;
      logic [199:0] key;
      logic [119:0] city;
      int s;
      r = '{pmld_pkg::ST_MISS, 5'd0, 64'd0, 56'd0, 8'd0};
      key = trim(key_raw, 25);
      city = 120'(trim({80'd0, city_raw}, 15));
      if (src < LISTS && (k != pmld_pkg::KIND_MOVE || dst < LISTS)) begin
        if (k == pmld_pkg::KIND_INSERT) begin
          s = append(src, key, city, a);
          if (s < 0) r.st = pmld_pkg::ST_FULL;
          else begin r.st = pmld_pkg::ST_DONE; r.slot = s[4:0]; end
        end else begin
          s = find(src, key);
          if (s >= 0) begin
            r.st = pmld_pkg::ST_DONE;
            r.slot = s[4:0];
            if (k == pmld_pkg::KIND_REMOVE) unlink(src, s);
            else if (k == pmld_pkg::KIND_LOOKUP) begin
              r.c0 = cities[s][63:0]; r.c1 = cities[s][119:64]; r.age = ages[s];
            end else begin
              logic [199:0] mk;
              logic [119:0] mc;
              logic [7:0] ma;
              mk = keys[s]; mc = cities[s]; ma = ages[s];
              unlink(src, s);
              s = append(dst, mk, mc, ma);
              r.slot = (s < 0) ? 5'd0 : s[4:0];
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_word(logic [1:0] st, logic [4:0] slot, logic [63:0] c0,
                             logic [55:0] c1, logic [7:0] a);
      answer_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin $error("status exp %0d got %0d", e.st, st); errors++; end
      if (slot !== e.slot) begin
        $error("slot_index exp %0d got %0d", e.slot, slot); errors++;
      end
      if (c0 !== e.c0) begin $error("city_out_0 exp %h got %h", e.c0, c0); errors++; end
      if (c1 !== e.c1) begin $error("city_out_1 exp %h got %h", e.c1, c1); errors++; end
      if (a !== e.age) begin $error("age_out exp %0d got %0d", e.age, a); errors++; end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, done;
  logic [1:0] kind = 0, list_sel = 0, dest_list = 0;
  logic [63:0] nick_0 = 0, nick_1 = 0, nick_2 = 0, city_0 = 0;
  logic [7:0] nick_3 = 0, age_in = 0;
  logic [55:0] city_1 = 0;
  logic [1:0] status;
  logic [4:0] slot_index;
  logic [63:0] city_out_0;
  logic [55:0] city_out_1;
  logic [7:0] age_out;

  directory_board board = new();
  int idle_pct;
  logic [199:0] names [8];

  pooled_multi_list_directory #(.SLOTS(SLOTS), .LISTS(LISTS)) uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) board.check_word(status, slot_index, city_out_0, city_out_1, age_out);
  end

  // Present one word and hold it until accepted.
  task automatic send_word(pmld_pkg::kind_t k, int src, int dst, logic [199:0] key,
                           logic [119:0] city, logic [7:0] a);
    do @(negedge clk); while (idle_pct > 0 && $urandom_range(99) < idle_pct);
    kind <= k; list_sel <= 2'(src); dest_list <= 2'(dst);
    {nick_3, nick_2, nick_1, nick_0} <= key;
    {city_1, city_0} <= city;
    age_in <= a;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(k, src, dst, key, city, a);
    @(negedge clk);
    start <= 0;
  endtask

  function automatic logic [199:0] rand_text(int maxlen);
    logic [199:0] t;
    int n;
    t = '0;
    n = $urandom_range(maxlen, 1);
    for (int b = 0; b < n; b++) t[b*8 +: 8] = 8'($urandom_range(255, 1));
    return t;
  endfunction

  function automatic logic [199:0] rand_bits();
    return 200'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
  endfunction

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [199:0] k;
    board.clear();
    idle_pct = 0;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: empty lists, bad selectors, fill the pool, overflow, head removal.
    send_word(pmld_pkg::KIND_LOOKUP, 0, 0, 200'h41, 120'd0, 8'd1);
    send_word(pmld_pkg::KIND_REMOVE, 1, 0, 200'h41, 120'd0, 8'd1);
    send_word(pmld_pkg::KIND_MOVE, 2, 0, 200'h41, 120'd0, 8'd1);
    send_word(pmld_pkg::KIND_INSERT, 3, 0, 200'h41, 120'd0, 8'd1);
    send_word(pmld_pkg::KIND_INSERT, 0, 0, '1, '1, 8'd130);
    send_word(pmld_pkg::KIND_INSERT, 0, 0, 200'h00FF41, {8'h00, 112'hFFFF42}, 8'd1);
    send_word(pmld_pkg::KIND_LOOKUP, 0, 0, 200'h41, 120'd0, 8'd0);
    send_word(pmld_pkg::KIND_LOOKUP, 0, 0, '1, 120'd0, 8'd0);
    send_word(pmld_pkg::KIND_MOVE, 0, 3, '1, 120'd0, 8'd0);
    send_word(pmld_pkg::KIND_MOVE, 0, 0, '1, 120'd0, 8'd0);
    send_word(pmld_pkg::KIND_MOVE, 0, 2, 200'h41, 120'd0, 8'd0);
    send_word(pmld_pkg::KIND_REMOVE, 0, 0, '1, 120'd0, 8'd0);
    send_word(pmld_pkg::KIND_INSERT, 0, 0, 200'h0, 120'd0, 8'd7);
    for (int i = 0; i < 32; i++)
      send_word(pmld_pkg::KIND_INSERT, i % 3, 0, 200'(i + 100), 120'(i), 8'(i + 1));
    send_word(pmld_pkg::KIND_LOOKUP, 2, 0, 200'h41, 120'd0, 8'd0);

    // Random phases with a small key set so lookups hit often.
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 60 : (p == 3) ? 6 : 0;
      for (int i = 0; i < 8; i++) names[i] = rand_text(25);
      for (int i = 0; i < 270; i++) begin
        pmld_pkg::kind_t kk;
        kk = pmld_pkg::kind_t'(2'($urandom_range(3)));
        k = ($urandom_range(9) == 0) ? rand_bits() : names[$urandom_range(7)];
        send_word(kk, ($urandom_range(19) == 0) ? 3 : $urandom_range(2),
                  ($urandom_range(19) == 0) ? 3 : $urandom_range(2), k,
                  120'(($urandom_range(4) == 0) ? rand_bits() : rand_text(15)),
                  ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(130, 1)));
      end
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
